[hdl/tbp_pkg.sv]
package tbp_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_POINTS = 4'b0010,
        PH_DESC   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    localparam logic [1:0] KIND_X      = 2'd0;
    localparam logic [1:0] KIND_Y      = 2'd1;
    localparam logic [1:0] KIND_DESC   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MINPTS = 2'd2;
    localparam logic [1:0] REG_THRESH = 2'd3;

    localparam int HEADER_BYTES = 19;
    localparam logic [31:0] DESC_LIMIT = 32'h4400_0000;

    // front to back: one decoded word or a status
    typedef struct packed {
        logic        is_status;
        logic        ok;
        logic [1:0]  kind;
        logic [7:0]  point;
        logic [6:0]  column;
        logic [31:0] word;
    } tbp_item_t;

    // float bits of an unsigned 16-bit integer
    function automatic logic [31:0] int_to_float(input logic [15:0] v);
        logic [4:0]  p;
        logic [31:0] sh;
        p = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
                p = 5'(i);
        end
        sh = 32'(v) << (5'd23 - p);
        if (v == 16'd0)
            return 32'd0;
        return {1'b0, 8'(8'd127 + 8'(p)), sh[22:0]};
    endfunction

endpackage

[hdl/tbp_front.sv]
module tbp_front
    import tbp_pkg::*;
#(
    parameter int MAX_POINTS       = 256,
    parameter int DESCRIPTOR_WORDS = 128
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic [15:0]     image_width,
    input  logic [15:0]     image_height,
    input  logic [8:0]      min_points,
    input  logic [15:0]     score_threshold,
    input  logic [31:0]     wbound_f,
    input  logic [31:0]     hbound_f,
    output logic            push,
    output logic            push_two,
    output tbp_item_t       item_a,
    output tbp_item_t       item_b,
    input  logic            room_two
);
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int CW = (DESCRIPTOR_WORDS > 1) ? $clog2(DESCRIPTOR_WORDS) : 1;

    phase_t          phase_reg, phase_next;
    logic [4:0]      hoff_reg, hoff_next;
    logic [31:0]     shift_reg, shift_next;
    logic [1:0]      biw_reg, biw_next;
    logic [PW-1:0]   total_reg, total_next;
    logic [PW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic            isy_reg, isy_next;
    logic            failed_reg, failed_next;

    logic [15:0] v16;
    logic        bad, word_ok, emit_w, acc, ok_now;
    logic [31:0] w, bound;
    tbp_item_t   wi, si;

    assign in_ready = room_two;
    assign acc      = in_valid && in_ready;
    assign v16      = {in_byte, shift_reg[7:0]};
    assign w        = {in_byte, shift_reg[31:8]};
    assign bound    = isy_reg ? hbound_f : wbound_f;

    always_comb
    begin
        bad = 1'b0;
        case (hoff_reg)
            5'd0:    bad = in_byte != 8'h47;
            5'd1:    bad = in_byte != 8'h53;
            5'd2:    bad = in_byte != 8'h46;
            5'd3:    bad = in_byte != 8'h4D;
            5'd4:    bad = in_byte != 8'd2;
            5'd6:    bad = v16 != image_width;
            5'd8:    bad = v16 != image_height;
            5'd10:   bad = (v16 < 16'(min_points)) || (32'(v16) > 32'(MAX_POINTS));
            5'd12:   bad = 32'(v16) != 32'(DESCRIPTOR_WORDS);
            5'd13:   bad = in_byte != 8'd1;
            5'd14:   bad = in_byte != 8'd0;
            5'd16:   bad = v16 != 16'(min_points);
            5'd18:   bad = v16 != score_threshold;
            default: bad = 1'b0;
        endcase
    end

    always_comb
    begin
        if (phase_reg == PH_POINTS)
        begin
            if (w[31])
                word_ok = (w[30:0] == 31'd0) && (isy_reg ? image_height != 16'd0
                                                        : image_width != 16'd0);
            else
                word_ok = w < bound;
        end
        else
        begin
            if (w[31])
                word_ok = w[30:0] == 31'd0;
            else
                word_ok = w <= DESC_LIMIT;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hoff_next   = hoff_reg;
        shift_next  = shift_reg;
        biw_next    = biw_reg;
        total_next  = total_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        isy_next    = isy_reg;
        failed_next = failed_reg;
        emit_w      = 1'b0;
        if (acc && !failed_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    shift_next = {24'd0, in_byte};
                    if (hoff_reg == 5'd10)
                        total_next = PW'(v16);
                    if (bad)
                        failed_next = 1'b1;
                    else
                    begin
                        hoff_next = hoff_reg + 5'd1;
                        if (32'(hoff_reg) + 1 >= HEADER_BYTES)
                        begin
                            phase_next = (total_next == '0) ? PH_DONE : PH_POINTS;
                            shift_next = 32'd0;
                            biw_next   = 2'd0;
                        end
                    end
                end
                PH_DONE:
                    failed_next = 1'b1;
                PH_POINTS, PH_DESC:
                begin
                    shift_next = w;
                    biw_next   = biw_reg + 2'd1;
                    if (biw_reg == 2'd3)
                    begin
                        if (!word_ok)
                            failed_next = 1'b1;
                        else
                        begin
                            emit_w = 1'b1;
                            if (phase_reg == PH_POINTS)
                            begin
                                isy_next = !isy_reg;
                                if (isy_reg)
                                begin
                                    if (row_reg + PW'(1) >= total_reg)
                                    begin
                                        row_next   = '0;
                                        col_next   = '0;
                                        phase_next = PH_DESC;
                                    end
                                    else
                                        row_next = row_reg + PW'(1);
                                end
                            end
                            else if (32'(col_reg) + 1 >= DESCRIPTOR_WORDS)
                            begin
                                col_next = '0;
                                row_next = row_reg + PW'(1);
                                if (row_reg + PW'(1) >= total_reg)
                                    phase_next = PH_DONE;
                            end
                            else
                                col_next = col_reg + CW'(1);
                        end
                    end
                end
                default: phase_next = PH_HEADER;
            endcase
        end
        // status sees this byte's outcome, before the run is cleared
        ok_now = !failed_next && (phase_next == PH_DONE);
        if (acc && in_last)
        begin
            phase_next  = PH_HEADER;
            hoff_next   = 5'd0;
            shift_next  = 32'd0;
            biw_next    = 2'd0;
            total_next  = '0;
            row_next    = '0;
            col_next    = '0;
            isy_next    = 1'b0;
            failed_next = 1'b0;
        end
    end

    always_comb
    begin
        wi.is_status = 1'b0;
        wi.ok        = 1'b0;
        wi.kind      = (phase_reg == PH_POINTS) ? (isy_reg ? KIND_Y : KIND_X) : KIND_DESC;
        wi.point     = 8'(row_reg);
        wi.column    = (phase_reg == PH_POINTS) ? 7'd0 : 7'(col_reg);
        wi.word      = w;
        si.is_status = 1'b1;
        si.ok        = ok_now;
        si.kind      = KIND_STATUS;
        si.point     = 8'd0;
        si.column    = 7'd0;
        si.word      = 32'd0;
        push     = acc && (emit_w || in_last);
        push_two = acc && emit_w && in_last;
        item_a   = emit_w ? wi : si;
        item_b   = si;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hoff_reg   <= 5'd0;
            shift_reg  <= 32'd0;
            biw_reg    <= 2'd0;
            total_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            isy_reg    <= 1'b0;
            failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hoff_reg   <= hoff_next;
            shift_reg  <= shift_next;
            biw_reg    <= biw_next;
            total_reg  <= total_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            isy_reg    <= isy_next;
            failed_reg <= failed_next;
        end
    end
endmodule

[hdl/tbp_queue.sv]
module tbp_queue
    import tbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       push_two,
    input  tbp_item_t  item_a,
    input  tbp_item_t  item_b,
    output logic       room_two,
    output logic       out_valid,
    input  logic       out_ready,
    output tbp_item_t  head
);
    tbp_item_t   mem_reg [4];
    logic [1:0]  rd_reg, wr_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid = cnt_reg != 3'd0;
    assign pop       = out_valid && out_ready;
    assign head      = mem_reg[rd_reg];
    // two free slots so a word plus a status always fit
    assign room_two  = cnt_reg <= 3'd2;

    always_comb
    begin
        cnt_next = cnt_reg + (push ? 3'd1 : 3'd0) + (push_two ? 3'd1 : 3'd0)
                   - (pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= item_a;
        if (push_two)
            mem_reg[wr_reg + 2'd1] <= item_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 2'd0;
            wr_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            wr_reg  <= wr_reg + (push ? 2'd1 : 2'd0) + (push_two ? 2'd1 : 2'd0);
            cnt_reg <= cnt_next;
        end
    end
endmodule

[hdl/template_blob_parser_core.sv]
// Template blob parser.
// Slave stream: one blob byte per word in s_axis_tdata, tlast on the final
// byte. Master stream: tdata carries {word, column, point}, tuser the kind,
// tlast marks the status word; a status word carries the ok flag in tuser.
// A blob is a 19-byte header, then x/y float words per point, then
// descriptor words; checked words go out, the first failure suppresses the
// rest, and the final byte always yields one status word.
// Throughput: one byte per cycle while the queue has room for two entries.
// A word is written straight into a four-entry queue and offered on the
// master side from the queue head. The front stalls only when the queue
// has fewer than two free slots, so a stalled receiver backs up into
// s_axis_tready once the queue holds three entries. Reset clears parse state
// and the queue and loads the register defaults (108, 88, 25, 40). The user
// must write registers through the APB port while idle; the block does not enforce it.
module template_blob_parser_core
    import tbp_pkg::*;
#(
    parameter int MAX_POINTS       = 256,
    parameter int DESCRIPTOR_WORDS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_point, [14:8] out_column, [46:15] out_word
    output logic [2:0]  m_axis_tuser,   // [1:0] out_kind, [2] out_ok
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] width_reg, height_reg, thresh_reg;
    logic [8:0]  minpts_reg;
    logic [31:0] wbound_reg, hbound_reg;
    logic        push, push_two, room_two;
    tbp_item_t   item_a, item_b, head;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {16'd0, width_reg};
            REG_HEIGHT: prdata = {16'd0, height_reg};
            REG_MINPTS: prdata = {23'd0, minpts_reg};
            REG_THRESH: prdata = {16'd0, thresh_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd108;
            height_reg <= 16'd88;
            minpts_reg <= 9'd25;
            thresh_reg <= 16'd40;
            wbound_reg <= 32'h42D8_0000;
            hbound_reg <= 32'h42B0_0000;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_WIDTH:  width_reg  <= pwdata[15:0];
                    REG_HEIGHT: height_reg <= pwdata[15:0];
                    REG_MINPTS: minpts_reg <= pwdata[8:0];
                    REG_THRESH: thresh_reg <= pwdata[15:0];
                    default:    ;
                endcase
            end
            // float bounds are registered from the width and height registers
            wbound_reg <= int_to_float(width_reg);
            hbound_reg <= int_to_float(height_reg);
        end
    end

    tbp_front #(
        .MAX_POINTS       (MAX_POINTS),
        .DESCRIPTOR_WORDS (DESCRIPTOR_WORDS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_byte         (s_axis_tdata),
        .in_last         (s_axis_tlast),
        .image_width     (width_reg),
        .image_height    (height_reg),
        .min_points      (minpts_reg),
        .score_threshold (thresh_reg),
        .wbound_f        (wbound_reg),
        .hbound_f        (hbound_reg),
        .push            (push),
        .push_two        (push_two),
        .item_a          (item_a),
        .item_b          (item_b),
        .room_two        (room_two)
    );

    tbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_two  (push_two),
        .item_a    (item_a),
        .item_b    (item_b),
        .room_two  (room_two),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .head      (head)
    );

    assign m_axis_tdata = {1'b0, head.word, head.column, head.point};
    assign m_axis_tuser = {head.ok, head.kind};
    assign m_axis_tlast = head.is_status;
endmodule

[verif/template_blob_parser_core_tb.sv]
`timescale 1ns / 100ps

module template_blob_parser_core_tb
    import tbp_pkg::*;
;

    localparam int NPTS_MAX  = 256;
    localparam int DESC_N    = 128;
    localparam int CYCLE_CAP = 3000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  point;
        logic [6:0]  column;
        logic [31:0] word;
        logic        ok;
        logic        last;
    } parse_word_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } blob_byte_t;

    // directed row: one byte, with the status typed in where it is obvious
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic       exp_ok;
    } direct_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    template_blob_parser_core dut (.*);

    // register shadow and parse state
    logic [15:0] cfg_width, cfg_height, cfg_thresh;
    logic [8:0]  cfg_minpts;
    phase_t      ps_phase;
    logic [4:0]  ps_hoff;
    logic [31:0] ps_shift;
    logic [1:0]  ps_bytepos;
    logic [15:0] ps_total;
    logic [15:0] ps_row;
    logic [7:0]  ps_col;
    logic        ps_isy;
    logic        ps_failed;

    parse_word_t expected_words[$];
    blob_byte_t  blob[$];
    direct_row_t direct_rows [4];
    int          mismatches;
    int          cycles;
    int          rx_gap;
    bit          rx_hold;
    bit          send_pause;
    bit          typed_row;
    logic        typed_ok;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] to_float_bits(input logic [15:0] v);
        logic [31:0] r;
        int          msb;
        r = 32'd0;
        msb = 0;
        for (int i = 0; i < 16; i++)
            if (v[i])
                msb = i;
        if (v != 16'd0)
        begin
            r[30:23] = 8'(127 + msb);
            r[22:0] = 23'((32'(v) << (23 - msb)) & 32'h7F_FFFF);
        end
        return r;
    endfunction

    function automatic logic coord_passes(input logic [31:0] w, input logic [15:0] bound);
        if (w[31])
            return (w[30:0] == 31'd0) && (bound != 16'd0);
        return w < to_float_bits(bound);
    endfunction

    function automatic logic desc_passes(input logic [31:0] w);
        if (w[31])
            return w[30:0] == 31'd0;
        return w <= DESC_LIMIT;
    endfunction

    task automatic clear_parse();
        ps_phase = PH_HEADER;
        ps_hoff = '0;
        ps_shift = '0;
        ps_bytepos = '0;
        ps_total = '0;
        ps_row = '0;
        ps_col = '0;
        ps_isy = 1'b0;
        ps_failed = 1'b0;
    endtask

    task automatic push_word(input logic [1:0] k, input logic [15:0] idx,
                             input logic [7:0] col, input logic [31:0] w,
                             input logic ok, input logic lst);
        parse_word_t e;
        e.kind = k;
        e.point = idx[7:0];
        e.column = col[6:0];
        e.word = w;
        e.ok = ok;
        e.last = lst;
        expected_words = {expected_words, e};
    endtask

    task automatic check_header_byte(input logic [7:0] b);
        logic [15:0] v16;
        logic        bad;
        logic [7:0]  magic [4];
        magic = '{8'h47, 8'h53, 8'h46, 8'h4D};
        v16 = {b, ps_shift[7:0]};
        bad = 1'b0;
        case (ps_hoff)
            0, 1, 2, 3: bad = (b != magic[ps_hoff]);
            4:  bad = (b != 8'd2);
            6:  bad = (v16 != cfg_width);
            8:  bad = (v16 != cfg_height);
            10:
            begin
                bad = (v16 < 16'(cfg_minpts)) || (v16 > 16'(NPTS_MAX));
                ps_total = v16;
            end
            12: bad = (v16 != 16'(DESC_N));
            13: bad = (b != 8'd1);
            14: bad = (b != 8'd0);
            16: bad = (v16 != 16'(cfg_minpts));
            18: bad = (v16 != cfg_thresh);
            default: bad = 1'b0;
        endcase
        ps_shift = 32'(b);
        if (bad)
            ps_failed = 1'b1;
        else
        begin
            ps_hoff = ps_hoff + 5'd1;
            if (ps_hoff >= 5'(HEADER_BYTES))
            begin
                ps_phase = (ps_total == 16'd0) ? PH_DONE : PH_POINTS;
                ps_shift = '0;
                ps_bytepos = '0;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic lst);
        logic [31:0] w;
        if (!ps_failed)
        begin
            if (ps_phase == PH_HEADER)
                check_header_byte(b);
            else if (ps_phase == PH_DONE)
                ps_failed = 1'b1;
            else
            begin
                ps_shift = {b, ps_shift[31:8]};
                ps_bytepos = ps_bytepos + 2'd1;
                if (ps_bytepos == 2'd0)
                begin
                    w = ps_shift;
                    if (ps_phase == PH_POINTS)
                    begin
                        if (!coord_passes(w, ps_isy ? cfg_height : cfg_width))
                            ps_failed = 1'b1;
                        else
                        begin
                            push_word(ps_isy ? KIND_Y : KIND_X, ps_row, 8'd0, w, 1'b0, 1'b0);
                            if (ps_isy)
                            begin
                                ps_isy = 1'b0;
                                ps_row++;
                                if (ps_row >= ps_total)
                                begin
                                    ps_row = '0;
                                    ps_col = '0;
                                    ps_phase = PH_DESC;
                                end
                            end
                            else
                                ps_isy = 1'b1;
                        end
                    end
                    else if (!desc_passes(w))
                        ps_failed = 1'b1;
                    else
                    begin
                        push_word(KIND_DESC, ps_row, ps_col, w, 1'b0, 1'b0);
                        ps_col++;
                        if (ps_col >= 8'(DESC_N))
                        begin
                            ps_col = '0;
                            ps_row++;
                            if (ps_row >= ps_total)
                                ps_phase = PH_DONE;
                        end
                    end
                end
            end
        end
        if (lst)
        begin
            push_word(KIND_STATUS, 16'd0, 8'd0, 32'd0,
                      typed_row ? typed_ok : (!ps_failed && ps_phase == PH_DONE), 1'b1);
            clear_parse();
        end
    endtask

    // blob building
    task automatic add_bytes(input logic [31:0] v, input int n);
        blob_byte_t x;
        for (int i = 0; i < n; i++)
        begin
            x.data = v[8*i +: 8];
            x.last = 1'b0;
            blob = {blob, x};
        end
    endtask

    function automatic logic [31:0] rand_coord(input logic [15:0] bound);
        logic [31:0] r;
        r = to_float_bits(16'($urandom_range(0, bound == 0 ? 0 : bound - 1)));
        // random low mantissa keeps the value below the bound's exponent step
        if (r != 0 && $urandom_range(0, 1))
            r[7:0] = 8'($urandom);
        return r;
    endfunction

    function automatic logic [31:0] rand_desc();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return DESC_LIMIT;
            default: return 32'($urandom_range(0, 32'h43FF_FFFF));
        endcase
    endfunction

    // hdr_fault: 0 none, else one header byte corrupted; body_fault: bad word
    task automatic build_blob(input int npts, input int hdr_fault, input int body_fault,
                              input int len_delta);
        int          start;
        int          words;
        int          bad_at;
        logic [31:0] w;
        start = blob.size();
        add_bytes(32'h4D46_5347, 4);
        add_bytes(32'd2, 1);
        add_bytes(32'(cfg_width), 2);
        add_bytes(32'(cfg_height), 2);
        add_bytes(32'(npts), 2);
        add_bytes(32'(DESC_N), 2);
        add_bytes(32'd1, 1);
        add_bytes(32'd0, 1);
        add_bytes(32'(cfg_minpts), 2);
        add_bytes(32'(cfg_thresh), 2);
        if (hdr_fault != 0)
            blob[start + $urandom_range(0, 18)].data ^= 8'(1 << $urandom_range(0, 7));
        words = npts * 2 + npts * DESC_N;
        // bad word lands early so that cut blobs still carry it
        bad_at = (body_fault != 0) ? $urandom_range(0, (words < 8) ? words - 1 : 7) : -1;
        for (int i = 0; i < words; i++)
        begin
            if (i < npts * 2)
                w = rand_coord((i % 2) ? cfg_height : cfg_width);
            else
                w = rand_desc();
            if (i == bad_at)
            begin
                case ($urandom_range(0, 3))
                    0: w = 32'h7F80_0000;
                    1: w = 32'h7FC0_0001;
                    2: w = 32'hBF80_0000;
                    default: w = (i < npts * 2) ? 32'h4780_0000 : 32'h4400_0001;
                endcase
            end
            add_bytes(w, 4);
        end
        for (int i = 0; i < len_delta; i++)
            add_bytes($urandom, 1);
        for (int i = 0; i < -len_delta && blob.size() > start + 1; i++)
            void'(blob.pop_back());
        blob[blob.size() - 1].last = 1'b1;
    endtask

    // blob cut to keep bytes, last flag on the final kept byte
    task automatic build_cut(input int npts, input int hdr_fault, input int body_fault,
                             input int keep);
        build_blob(npts, hdr_fault, body_fault,
                   keep - (HEADER_BYTES + npts * 8 + npts * DESC_N * 4));
    endtask

    task automatic add_raw(input logic [7:0] b, input logic lst);
        blob_byte_t x;
        x.data = b;
        x.last = lst;
        blob = {blob, x};
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return;
        s_axis_tvalid <= 1'b0;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40))
            @(negedge clk);
    endtask

    task automatic send_blob();
        while (blob.size() > 0)
        begin
            if (!send_pause)
                idle_gap();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= blob[0].data;
            s_axis_tlast <= blob[0].last;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            predict_byte(blob[0].data, blob[0].last);
            void'(blob.pop_front());
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        while (expected_words.size() > 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'({idx, 2'b00});
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width = v[15:0];
            REG_HEIGHT: cfg_height = v[15:0];
            REG_MINPTS: cfg_minpts = v[8:0];
            default:    cfg_thresh = v[15:0];
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h,
                             input logic [8:0] m, input logic [15:0] t);
        wait_drain();
        apb_write(REG_WIDTH, 32'(w));
        apb_write(REG_HEIGHT, 32'(h));
        apb_write(REG_MINPTS, 32'(m));
        apb_write(REG_THRESH, 32'(t));
    endtask

    // receiver with random stalls, mostly short; rx_hold forces a long hold-off
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n || rx_hold)
            m_axis_tready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (r < 70)
            m_axis_tready <= 1'b1;
        else
        begin
            rx_gap = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        parse_word_t got, exp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.point = m_axis_tdata[7:0];
            got.column = m_axis_tdata[14:8];
            got.word = m_axis_tdata[46:15];
            got.kind = m_axis_tuser[1:0];
            got.ok = m_axis_tuser[2];
            got.last = m_axis_tlast;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %p", got);
            end
            else
            begin
                exp = expected_words.pop_front();
                if (got !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        cycles = 0;
        rx_gap = 0;
        rx_hold = 1'b0;
        send_pause = 1'b0;
        typed_row = 1'b0;
        typed_ok = 1'b0;
        cfg_width = 16'd108;
        cfg_height = 16'd88;
        cfg_minpts = 9'd25;
        cfg_thresh = 16'd40;
        clear_parse();
        direct_rows = '{
            '{8'h47, 1'b1, 1'b1, 1'b0},     // early last after the first magic byte
            '{8'hFF, 1'b1, 1'b1, 1'b0},     // wrong magic, alone
            '{8'h00, 1'b0, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, 1'b0}      // failed run ends invalid
        };
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: status-only blobs at reset defaults
        foreach (direct_rows[i])
        begin
            typed_row = direct_rows[i].typed;
            typed_ok = direct_rows[i].exp_ok;
            add_raw(direct_rows[i].data, direct_rows[i].last);
            send_blob();
        end
        typed_row = 1'b0;
        wait_drain();
        // zero points, extremes of width and height, an extra byte and a cut blob
        configure(16'hFFFF, 16'd1, 9'd0, 16'hFFFF);
        build_blob(0, 0, 0, 0);
        build_blob(0, 0, 0, 1);
        build_blob(0, 0, 0, -3);
        send_blob();
        // one point, all registers minimal-ish
        configure(16'd0, 16'd0, 9'd1, 16'd0);
        build_cut(1, 0, 0, 40);
        send_blob();
        configure(16'd1, 16'd1, 9'd1, 16'd0);
        build_blob(1, 0, 0, 0);
        build_cut(1, 0, 1, 60);
        send_blob();

        // random: short cuts of varied blobs, one full blob, varied config
        for (int phase_i = 0; phase_i < 6; phase_i++)
        begin
            case (phase_i)
                0: configure(16'd108, 16'd88, 9'd1, 16'd40);
                1: configure(16'hFFFF, 16'hFFFF, 9'd2, 16'hFFFF);
                2: configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                             9'd1, 16'($urandom));
                3: configure(16'd3, 16'd5, 9'd256, 16'd7);
                4: configure(16'd640, 16'd480, 9'h1FF, 16'd1);
                default: configure(16'd108, 16'd88, 9'd1, 16'd40);
            endcase
            n = 2;
            for (int b = 0; b < n; b++)
            begin
                int np, r;
                r = $urandom_range(0, 9);
                np = (phase_i == 3) ? 256 : $urandom_range(1, 2);
                if (phase_i == 4)
                    np = 1;
                if (phase_i == 0 && b == 0)
                    build_blob(1, 0, 0, 0);
                else if (phase_i == 1 && b == 0)
                    build_cut(2, 0, 0, 140);
                else if (r < 6)
                    build_cut(np, 0, 0, $urandom_range(HEADER_BYTES, 80));
                else if (r == 6)
                    build_cut(np, 1, 0, $urandom_range(HEADER_BYTES, 80));
                else if (r == 7)
                    build_cut(np, 0, 1, $urandom_range(HEADER_BYTES, 80));
                else
                    build_cut(np, 0, 0, $urandom_range(1, HEADER_BYTES - 1));
                if (phase_i == 1 && b == 0)
                begin
                    // long receiver hold-off while bytes keep coming
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (200)
                                @(negedge clk);
                            rx_hold = 1'b0;
                        end
                        send_blob();
                    join
                end
                else
                    send_blob();
                if (phase_i == 2 && b == 1)
                begin
                    send_pause = 1'b1;
                    wait_drain();
                    send_pause = 1'b0;
                end
            end
        end

        wait_drain();
        repeat (20)
            @(negedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
